@@ rtl/core/dmps_pkg.sv @@
// Shared types and constants for the diamond maximum path sum block.
`default_nettype none

package dmps_pkg;

    localparam int VALUE_W = 16;
    localparam int SUM_W   = 24;
    localparam int CFG_W   = 8;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Which predecessors a cell draws from
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_TOP      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FIRST    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LAST_COL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MID      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NARROW   = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              last;
    } dmps_ctl_t;

    localparam int CTL_W = $bits(dmps_ctl_t);

endpackage

`default_nettype wire

@@ rtl/core/diamond_max_path_sum.sv @@
// Top level of the diamond grid maximum path sum block.
// Cells pass the queue, read stage and output register: one cell per cycle
// unless m_tready stalls, set by one row store read and write per cell.
// Reset: grid size 1, position at row 1 column 1, queue and output empty;
// the row store is not cleared and holds nothing meaningful until written.
`default_nettype none

module diamond_max_path_sum #(
    parameter int MAX_N = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,  // grid_size
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,    // [15:0] cell_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,    // [23:0] path_sum
    output logic             m_tlast
);

    import dmps_pkg::*;

    localparam int AW  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CWB = $clog2(2 * MAX_N + 1);
    localparam int CW  = (CWB > CFG_W + 1) ? CWB : CFG_W + 1;
    localparam int QW  = VALUE_W + CTL_W + 2 * AW;

    logic               push_valid;
    logic               push_ready;
    logic [VALUE_W-1:0] push_value;
    dmps_ctl_t          push_ctl;
    logic [AW-1:0]      push_addr_a;
    logic [AW-1:0]      push_addr_b;
    logic [QW-1:0]      push_data;

    logic               q_valid;
    logic               q_pop;
    logic [QW-1:0]      q_data;
    logic [VALUE_W-1:0] q_value;
    dmps_ctl_t          q_ctl;
    logic [AW-1:0]      q_addr_a;
    logic [AW-1:0]      q_addr_b;

    dmps_front #(
        .MAX_N (MAX_N),
        .CW    (CW),
        .AW    (AW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_value    (s_tdata),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_value  (push_value),
        .push_ctl    (push_ctl),
        .push_addr_a (push_addr_a),
        .push_addr_b (push_addr_b)
    );

    assign push_data = {push_addr_b, push_addr_a, push_ctl, push_value};

    dmps_queue #(
        .W (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    assign {q_addr_b, q_addr_a, q_ctl, q_value} = q_data;

    dmps_back #(
        .MAX_N (MAX_N),
        .AW    (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_value   (q_value),
        .q_ctl     (q_ctl),
        .q_addr_a  (q_addr_a),
        .q_addr_b  (q_addr_b),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sum   (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/core/dmps_ram.sv @@
// Generic RAM: one write port, two registered read ports sharing an enable.
`default_nettype none

module dmps_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [WIDTH-1:0]  rdata_a,
    output logic      [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/dmps_front.sv @@
// Front end: grid position counters and per-cell classification.
`default_nettype none

module dmps_front #(
    parameter int MAX_N = 128,
    parameter int CW    = 9,
    parameter int AW    = 7
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [dmps_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [dmps_pkg::VALUE_W-1:0]  in_value,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output logic      [dmps_pkg::VALUE_W-1:0]  push_value,
    output dmps_pkg::dmps_ctl_t                push_ctl,
    output logic      [AW-1:0]                 push_addr_a,
    output logic      [AW-1:0]                 push_addr_b
);

    import dmps_pkg::*;

    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] cfg_n;
    logic [CW-1:0] cfg_ext;
    logic [CW-1:0] last_row;
    logic [CW-1:0] row_len;
    logic          widen;
    logic          is_last;
    logic          accept;

    assign in_ready   = push_ready;
    assign accept     = in_valid && push_ready;
    assign push_valid = in_valid;
    assign push_value = in_value;

    assign widen    = (row_reg <= n_reg);
    assign last_row = (n_reg << 1) - CW'(1);
    assign row_len  = widen ? row_reg : ((n_reg << 1) - row_reg);
    assign is_last  = (row_reg >= last_row) && (col_reg >= row_len);

    assign push_addr_a = AW'(col_reg - CW'(1));
    assign push_addr_b = AW'(col_reg);

    always_comb
    begin
        push_ctl.last = is_last;
        priority if (row_reg == CW'(1))
        begin
            push_ctl.kind = KIND_TOP;
        end
        else if (!widen)
        begin
            push_ctl.kind = KIND_NARROW;
        end
        else if (col_reg == CW'(1))
        begin
            push_ctl.kind = KIND_FIRST;
        end
        else if (col_reg >= row_reg)
        begin
            push_ctl.kind = KIND_LAST_COL;
        end
        else
        begin
            push_ctl.kind = KIND_MID;
        end
    end

    // Clamp the written size into 1..MAX_N
    assign cfg_ext = CW'(cfg_wdata);

    always_comb
    begin
        priority if (cfg_wdata == '0)
        begin
            cfg_n = CW'(1);
        end
        else if (cfg_ext > CW'(MAX_N))
        begin
            cfg_n = CW'(MAX_N);
        end
        else
        begin
            cfg_n = cfg_ext;
        end
    end

    always_comb
    begin
        n_next   = n_reg;
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_we)
        begin
            n_next   = cfg_n;
            row_next = CW'(1);
            col_next = CW'(1);
        end
        else if (accept)
        begin
            priority if (is_last)
            begin
                row_next = CW'(1);
                col_next = CW'(1);
            end
            else if (col_reg >= row_len)
            begin
                row_next = row_reg + CW'(1);
                col_next = CW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg   <= CW'(1);
            row_reg <= CW'(1);
            col_reg <= CW'(1);
        end
        else
        begin
            n_reg   <= n_next;
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

`ifndef SYNTHESIS
    a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg >= CW'(1)) && (row_reg <= last_row))
        else $error("row counter left the grid");

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg >= CW'(1)) && (col_reg <= row_len))
        else $error("column counter left the row");
`endif

endmodule

`default_nettype wire

@@ rtl/core/dmps_queue.sv @@
// Two-entry queue between the front end and the back end.
`default_nettype none

module dmps_queue #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push_valid,
    output logic              push_ready,
    input  wire logic [W-1:0] push_data,
    output logic              pop_valid,
    input  wire logic         pop,
    output logic      [W-1:0] pop_data
);

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != 2'd0))
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

@@ rtl/core/dmps_back.sv @@
// Back end: row store read, best predecessor, saturating add, output register.
`default_nettype none

module dmps_back #(
    parameter int MAX_N = 128,
    parameter int AW    = 7
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    output logic                               q_pop,
    input  wire logic [dmps_pkg::VALUE_W-1:0]  q_value,
    input  wire dmps_pkg::dmps_ctl_t           q_ctl,
    input  wire logic [AW-1:0]                 q_addr_a,
    input  wire logic [AW-1:0]                 q_addr_b,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [dmps_pkg::SUM_W-1:0]    out_sum,
    output logic                               out_last
);

    import dmps_pkg::*;

    logic                b2_valid_reg, b2_valid_next;
    logic [VALUE_W-1:0]  b2_value_reg;
    dmps_ctl_t           b2_ctl_reg;
    logic [AW-1:0]       b2_addr_reg;
    logic                byp_a_reg;
    logic                byp_b_reg;
    logic [SUM_W-1:0]    byp_sum_reg;
    logic [SUM_W-1:0]    held_reg;
    logic                out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]    out_sum_reg;
    logic                out_last_reg;

    logic [SUM_W-1:0]    rd_a;
    logic [SUM_W-1:0]    rd_b;
    logic [SUM_W-1:0]    above;
    logic [SUM_W-1:0]    right;
    logic [SUM_W-1:0]    pred;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum;
    logic                out_free;
    logic                b2_move;
    logic                b2_ready;

    assign out_free = !out_valid_reg || out_ready;
    assign b2_move  = b2_valid_reg && out_free;
    assign b2_ready = !b2_valid_reg || out_free;
    assign q_pop    = q_valid && b2_ready;

    dmps_ram #(
        .WIDTH  (SUM_W),
        .DEPTH  (MAX_N),
        .ADDR_W (AW)
    ) u_row_store (
        .clk     (clk),
        .we      (b2_move),
        .waddr   (b2_addr_reg),
        .wdata   (sum),
        .re      (q_pop),
        .raddr_a (q_addr_a),
        .raddr_b (q_addr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // The write made on the read edge is not in the read data: forward it
    assign above = byp_a_reg ? byp_sum_reg : rd_a;
    assign right = byp_b_reg ? byp_sum_reg : rd_b;

    always_comb
    begin
        unique case (b2_ctl_reg.kind)
            KIND_FIRST:    pred = above;
            KIND_LAST_COL: pred = held_reg;
            KIND_MID:      pred = (above > held_reg) ? above : held_reg;
            KIND_NARROW:   pred = (above > right) ? above : right;
            default:       pred = '0;
        endcase
    end

    assign sum_wide = {1'b0, pred} + (SUM_W + 1)'(b2_value_reg);
    assign sum      = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    always_comb
    begin
        b2_valid_next = b2_valid_reg;
        if (q_pop)
        begin
            b2_valid_next = 1'b1;
        end
        else if (b2_move)
        begin
            b2_valid_next = 1'b0;
        end
        out_valid_next = out_free ? b2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b2_value_reg <= q_value;
            b2_ctl_reg   <= q_ctl;
            b2_addr_reg  <= q_addr_a;
            byp_a_reg    <= b2_move && (b2_addr_reg == q_addr_a);
            byp_b_reg    <= b2_move && (b2_addr_reg == q_addr_b);
            byp_sum_reg  <= sum;
        end
        if (b2_move)
        begin
            out_sum_reg  <= sum;
            out_last_reg <= b2_ctl_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            b2_valid_reg  <= b2_valid_next;
            out_valid_reg <= out_valid_next;
            if (b2_move)
            begin
                held_reg <= above;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    a_sum_covers_value: assert property (@(posedge clk) disable iff (!rst_n)
        b2_move |-> (sum >= SUM_W'(b2_value_reg)))
        else $error("path sum below cell value");

    a_top_at_col_one: assert property (@(posedge clk) disable iff (!rst_n)
        (b2_valid_reg && (b2_ctl_reg.kind == KIND_TOP)) |-> (b2_addr_reg == '0))
        else $error("top row cell away from first column");

    a_pop_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> b2_valid_reg)
        else $error("popped request lost");
`endif

endmodule

`default_nettype wire
